@@ rtl/assert_macros.svh @@
// Assertion macros for the stall histogram core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/slh_pkg.sv @@
`timescale 1ns / 1ps

package slh_pkg;

    localparam int BUCKETS = 16;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W   = 4;
    localparam int TS_W    = 64;
    localparam int MIN_W   = 48;
    localparam int CNT_W   = 32;

    localparam logic [MIN_W-1:0] MIN_STALL_RESET = MIN_W'(1000);
    localparam logic [CNT_W-1:0] CNT_MAX         = '1;

    typedef enum logic [1:0] {
        ACT_BASELINE = 2'd0,
        ACT_SAMPLE   = 2'd1,
        ACT_READ     = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [TS_W-1:0]     timestamp;
        logic [IDX_W-1:0]    bucket_select;
    } item_t;

    typedef struct packed {
        logic                stall_counted;
        logic [IDX_W-1:0]    bucket_index;
        logic [CNT_W-1:0]    bucket_count;
        logic [TS_W-1:0]     lost_ticks;
    } result_t;

    typedef struct packed {
        logic                valid;
        action_t             action;
        logic [IDX_W-1:0]    bucket_select;
        logic                changed;
        logic [TS_W-1:0]     gap;
    } gap_stage_t;

    typedef struct packed {
        logic                valid;
        action_t             action;
        logic                stall;
        logic [IDX_W-1:0]    index;
        logic [TS_W-1:0]     gap;
    } bucket_stage_t;

endpackage

@@ rtl/slh_gap.sv @@
`timescale 1ns / 1ps

module slh_gap import slh_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       item_valid,
    input  item_t      item,
    output gap_stage_t gap_stage
);

    logic            in_valid_reg;
    logic            in_valid_next;
    item_t           in_reg;
    logic [TS_W-1:0] prev_ts_reg;
    logic [TS_W-1:0] prev_ts_next;
    gap_stage_t      gap_reg;
    gap_stage_t      gap_next;
    logic            changed;

    assign changed = (in_reg.timestamp != prev_ts_reg);

    always_comb
    begin
        in_valid_next = advance ? item_valid : in_valid_reg;
        prev_ts_next  = prev_ts_reg;
        gap_next      = gap_reg;
        if (advance)
        begin
            gap_next.valid         = in_valid_reg;
            gap_next.action        = in_reg.action;
            gap_next.bucket_select = in_reg.bucket_select;
            gap_next.changed       = changed;
            gap_next.gap           = in_reg.timestamp - prev_ts_reg;
            if (in_valid_reg)
            begin
                case (in_reg.action)
                    ACT_BASELINE: prev_ts_next = in_reg.timestamp;
                    ACT_SAMPLE:
                    begin
                        if (changed)
                        begin
                            prev_ts_next = in_reg.timestamp;
                        end
                    end
                    default: prev_ts_next = prev_ts_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            prev_ts_reg  <= '0;
            gap_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            prev_ts_reg  <= prev_ts_next;
            gap_reg      <= gap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_reg <= item;
        end
    end

    assign gap_stage = gap_reg;

endmodule

@@ rtl/slh_bucket.sv @@
`timescale 1ns / 1ps

module slh_bucket import slh_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [MIN_W-1:0] min_stall,
    input  gap_stage_t       gap_stage,
    output bucket_stage_t    bucket_stage
);

    logic [BUCKETS-1:0] hit;
    logic [IDX_W-1:0]   pick;
    bucket_stage_t      bkt_reg;
    bucket_stage_t      bkt_next;

    // compare against every boundary in parallel
    always_comb
    begin
        for (int i = 0; i < BUCKETS; i++)
        begin
            hit[i] = (gap_stage.gap >= (TS_W'(min_stall) << i));
        end
    end

    // highest reached boundary wins
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < BUCKETS; i++)
        begin
            if (hit[i])
            begin
                pick = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        bkt_next = bkt_reg;
        if (advance)
        begin
            bkt_next.valid  = gap_stage.valid;
            bkt_next.action = gap_stage.action;
            bkt_next.gap    = gap_stage.gap;
            bkt_next.stall  = (gap_stage.action == ACT_SAMPLE) && gap_stage.changed && hit[0];
            bkt_next.index  = (gap_stage.action == ACT_READ) ? gap_stage.bucket_select : pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_reg <= '0;
        end
        else
        begin
            bkt_reg <= bkt_next;
        end
    end

    assign bucket_stage = bkt_reg;

endmodule

@@ rtl/slh_count.sv @@
`timescale 1ns / 1ps

module slh_count import slh_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  bucket_stage_t bucket_stage,
    output logic          result_valid,
    output result_t       result
);

    logic [CNT_W-1:0] cnt_reg [BUCKETS];
    logic [CNT_W-1:0] cnt_next [BUCKETS];
    logic [TS_W-1:0]  total_reg;
    logic [TS_W-1:0]  total_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    result_t          result_reg;
    result_t          result_next;
    logic [BKT_W-1:0] addr;
    logic             in_range;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] inc;

    assign addr     = bucket_stage.index[BKT_W-1:0];
    assign in_range = (32'(bucket_stage.index) < 32'(BUCKETS));
    assign cur      = cnt_reg[addr];
    assign inc      = (cur != CNT_MAX) ? cur + CNT_W'(1) : cur;

    always_comb
    begin
        cnt_next          = cnt_reg;
        total_next        = total_reg;
        result_next       = result_reg;
        result_valid_next = advance ? bucket_stage.valid : result_valid_reg;
        if (advance && bucket_stage.valid)
        begin
            result_next = '0;
            case (bucket_stage.action)
                ACT_SAMPLE:
                begin
                    if (bucket_stage.stall)
                    begin
                        total_next                = total_reg + bucket_stage.gap;
                        cnt_next[addr]            = inc;
                        result_next.stall_counted = 1'b1;
                        result_next.bucket_index  = bucket_stage.index;
                        result_next.bucket_count  = inc;
                    end
                end
                ACT_READ:
                begin
                    result_next.bucket_index = bucket_stage.index;
                    result_next.bucket_count = in_range ? cur : '0;
                end
                ACT_CLEAR:
                begin
                    for (int i = 0; i < BUCKETS; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    total_next = '0;
                end
                default: total_next = total_reg;
            endcase
            result_next.lost_ticks = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg          <= cnt_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/stall_log2_histogram_core.sv @@
// A result word passes through the input, gap, bucket and result registers,
// the input register loading at the edge that accepts its input word.
// Throughput: one word per cycle; the pipe holds as a whole while a result
// word waits under stall.
// Reset (rst_n, async, active low) clears the baseline, all bucket counters
// and the lost-tick total, and loads min_stall_ticks with 1000.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module stall_log2_histogram_core import slh_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MIN_W-1:0] cfg_data
);

    logic             advance;
    logic [MIN_W-1:0] min_stall_reg;
    logic [MIN_W-1:0] min_stall_next;
    gap_stage_t       gap_stage;
    bucket_stage_t    bucket_stage;

    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;
    assign cfg_ready  = 1'b1;

    assign min_stall_next = (cfg_valid && cfg_ready) ? cfg_data : min_stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_stall_reg <= MIN_STALL_RESET;
        end
        else
        begin
            min_stall_reg <= min_stall_next;
        end
    end

    slh_gap u_gap (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item),
        .gap_stage  (gap_stage)
    );

    slh_bucket u_bucket (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .min_stall    (min_stall_reg),
        .gap_stage    (gap_stage),
        .bucket_stage (bucket_stage)
    );

    slh_count u_count (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .bucket_stage (bucket_stage),
        .result_valid (result_valid),
        .result       (result)
    );

    `ASSERT_ALWAYS(a_stall_needs_result, clk, rst_n, !item_stall || result_valid)
    `ASSERT_ALWAYS(a_counted_nonzero, clk, rst_n,
        !(result_valid && result.stall_counted) || (result.bucket_count != '0))
    `ASSERT_NEXT(a_stall_flag_sample, clk, rst_n,
        advance && bucket_stage.valid && bucket_stage.stall,
        result_valid && result.stall_counted)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import slh_pkg::*;

    localparam int SETTLE      = 8;
    localparam int PHASE_WORDS = 200;
    localparam int PHASES      = 8;
    localparam int MAX_GAP     = 20;

    typedef struct {
        item_t   word;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [MIN_W-1:0] cfg_data     = '0;

    logic [MIN_W-1:0] min_ticks;
    logic [TS_W-1:0]  last_ts;
    logic [CNT_W-1:0] bucket_hits [BUCKETS];
    logic [TS_W-1:0]  ticks_lost;

    result_t   expected_q [$];
    stim_row_t stim_rows [$];
    int        fail_count   = 0;
    int        send_idle    = 0;
    int        recv_stall   = 0;

    stall_log2_histogram_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void clear_histogram();
        for (int k = 0; k < BUCKETS; k++)
            bucket_hits[k] = '0;
        ticks_lost = '0;
    endfunction

    function automatic result_t histogram_step(input item_t w);
        result_t         r;
        logic [TS_W-1:0] gap;
        logic [TS_W-1:0] floor_ticks;
        int              b;
        r           = '0;
        floor_ticks = {{(TS_W-MIN_W){1'b0}}, min_ticks};
        case (w.action)
            ACT_BASELINE: last_ts = w.timestamp;
            ACT_SAMPLE:
            begin
                if (w.timestamp != last_ts)
                begin
                    gap     = w.timestamp - last_ts;
                    last_ts = w.timestamp;
                    if (gap >= floor_ticks)
                    begin
                        b = 0;
                        for (int i = 1; i < BUCKETS; i++)
                            if (gap >= (floor_ticks << i))
                                b = i;
                        ticks_lost = ticks_lost + gap;
                        if (bucket_hits[b] != CNT_MAX)
                            bucket_hits[b] = bucket_hits[b] + 1'b1;
                        r.stall_counted = 1'b1;
                        r.bucket_index  = IDX_W'(b);
                        r.bucket_count  = bucket_hits[b];
                    end
                end
            end
            ACT_READ:
            begin
                r.bucket_index = w.bucket_select;
                if (int'(w.bucket_select) < BUCKETS)
                    r.bucket_count = bucket_hits[w.bucket_select];
            end
            default: clear_histogram();
        endcase
        r.lost_ticks = ticks_lost;
        return r;
    endfunction

    function automatic stim_row_t row(input action_t a, input logic [TS_W-1:0] ts,
                                      input logic [IDX_W-1:0] sel, input bit typed,
                                      input result_t want);
        stim_row_t s;
        s.word.action        = a;
        s.word.timestamp     = ts;
        s.word.bucket_select = sel;
        s.typed              = typed;
        s.want               = want;
        return s;
    endfunction

    function automatic logic [TS_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // pick a gap that lands below, on or around a bucket boundary
    function automatic logic [TS_W-1:0] pick_gap();
        logic [TS_W-1:0] floor_ticks;
        int              pick;
        floor_ticks = {{(TS_W-MIN_W){1'b0}}, min_ticks};
        pick        = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return (floor_ticks == 0) ? rand64() % 8 : rand64() % floor_ticks;
        if (pick == 7)
            return rand64();
        if (pick >= 8)
            return floor_ticks + ((floor_ticks == 0) ? 64'd0 : rand64() % floor_ticks);
        return (floor_ticks << $urandom_range(0, BUCKETS - 1))
               + TS_W'($urandom_range(0, 2)) - 64'd1;
    endfunction

    task automatic send_word(input item_t w, input bit typed, input result_t want);
        int      idle;
        result_t got;
        idle = 0;
        while (idle < MAX_GAP && $urandom_range(1, 100) <= send_idle)
            idle++;
        if (idle > 0)
        begin
            item_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        got = histogram_step(w);
        expected_q.push_back(typed ? want : got);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_min_ticks(input logic [MIN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        min_ticks  = v;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (recv_stall == 0)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(1, 100) <= recv_stall);
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result word %h", result);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.stall_counted != want.stall_counted
                    || result.bucket_index != want.bucket_index
                    || result.bucket_count != want.bucket_count
                    || result.lost_ticks != want.lost_ticks)
                begin
                    if (fail_count < 10)
                        $display("mismatch: stall %b/%b index %0d/%0d count %0d/%0d lost %h/%h",
                                 want.stall_counted, result.stall_counted,
                                 want.bucket_index, result.bucket_index,
                                 want.bucket_count, result.bucket_count,
                                 want.lost_ticks, result.lost_ticks);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        item_t            w;
        int               pick;
        logic [MIN_W-1:0] settings [PHASES];

        min_ticks = MIN_STALL_RESET;
        last_ts   = '0;
        clear_histogram();

        stim_rows.push_back(row(ACT_READ,     '0,    4'd0,  1, {1'b0, 4'd0,  32'd0, 64'd0}));
        stim_rows.push_back(row(ACT_READ,     '0,    4'd15, 1, {1'b0, 4'd15, 32'd0, 64'd0}));
        stim_rows.push_back(row(ACT_SAMPLE,   '0,    4'd7,  1, {1'b0, 4'd0,  32'd0, 64'd0}));
        stim_rows.push_back(row(ACT_SAMPLE,   64'd999, 4'd0, 1, {1'b0, 4'd0, 32'd0, 64'd0}));
        stim_rows.push_back(row(ACT_SAMPLE,   64'd1999, 4'd0, 1,
                                {1'b1, 4'd0, 32'd1, 64'd1000}));
        stim_rows.push_back(row(ACT_BASELINE, '0,    4'd0,  1,
                                {1'b0, 4'd0, 32'd0, 64'd1000}));
        stim_rows.push_back(row(ACT_SAMPLE,   '1,    4'd0,  1,
                                {1'b1, 4'd15, 32'd1, 64'd999}));
        stim_rows.push_back(row(ACT_SAMPLE,   '0,    4'd0,  1, {1'b0, 4'd0, 32'd0, 64'd999}));
        stim_rows.push_back(row(ACT_SAMPLE,   64'd2000, 4'd0, 1,
                                {1'b1, 4'd1, 32'd1, 64'd2999}));
        stim_rows.push_back(row(ACT_SAMPLE,   64'd3999, 4'd0, 1,
                                {1'b1, 4'd0, 32'd2, 64'd4998}));
        stim_rows.push_back(row(ACT_READ,     '1,    4'd0,  1,
                                {1'b0, 4'd0, 32'd2, 64'd4998}));
        stim_rows.push_back(row(ACT_READ,     '0,    4'd1,  0, '0));
        stim_rows.push_back(row(ACT_CLEAR,    '1,    4'd15, 1, {1'b0, 4'd0, 32'd0, 64'd0}));
        stim_rows.push_back(row(ACT_READ,     '0,    4'd15, 1, {1'b0, 4'd15, 32'd0, 64'd0}));
        stim_rows.push_back(row(ACT_SAMPLE,   64'd5000, 4'd0, 0, '0));
        stim_rows.push_back(row(ACT_BASELINE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd5, 0, '0));
        stim_rows.push_back(row(ACT_SAMPLE,   64'h5555_5555_5555_5555, 4'd10, 0, '0));
        stim_rows.push_back(row(ACT_SAMPLE,   64'h5555_5555_5555_5555, 4'd0, 0, '0));
        stim_rows.push_back(row(ACT_SAMPLE,   64'h5555_5555_5555_5555 + 64'd1000 * 64'd1024,
                                4'd0, 0, '0));
        stim_rows.push_back(row(ACT_READ,     '0,    4'd10, 0, '0));
        stim_rows.push_back(row(ACT_READ,     '1,    4'd5,  0, '0));
        stim_rows.push_back(row(ACT_CLEAR,    '0,    4'd0,  0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);

        settings[0] = 48'd0;
        settings[1] = '1;
        settings[2] = 48'd1;
        settings[3] = MIN_STALL_RESET;
        settings[4] = {16'($urandom), $urandom};
        settings[5] = 48'd7;
        settings[6] = 48'($urandom_range(1, 100000));
        settings[7] = {16'($urandom_range(0, 65535)), $urandom};

        for (int p = 0; p < PHASES; p++)
        begin
            write_min_ticks(settings[p]);
            send_idle  = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 15 : 0;
            recv_stall = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 15 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                w.timestamp     = rand64();
                w.bucket_select = IDX_W'($urandom);
                pick            = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    w.action    = ACT_SAMPLE;
                    w.timestamp = last_ts + pick_gap();
                end
                else if (pick < 82)
                    w.action = ACT_READ;
                else if (pick < 96)
                begin
                    w.action = ACT_BASELINE;
                    if (pick < 90)
                        w.timestamp = last_ts + pick_gap();
                end
                else
                    w.action = ACT_CLEAR;
                send_word(w, 0, '0);
            end
        end

        drain();
        send_idle  = 0;
        recv_stall = 0;
        repeat (SETTLE) @(posedge clk);
        fail_count = fail_count + expected_q.size();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
